// ===== rtl/tcs_pkg.sv =====
// Package for the trim cell statistics block: status codes, register indexes,
// field widths and the layout of one stored statistics entry.
// No dependencies.
`default_nettype none

package tcs_pkg;

    localparam int STATUS_W = 3;
    localparam int QTY_W    = 2;
    localparam int HITS_W   = 24;
    localparam int VALUE_W  = 14;
    localparam int TOTAL_W  = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 96;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIME  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RPM   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_CELL  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TEMP  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_MODE  = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMESTAMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COOLANT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_USE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELIABLE_HITS = 3'd4;

    localparam logic [QTY_W-1:0] QTY_TRIM = 2'd0;
    localparam logic [QTY_W-1:0] QTY_MAP  = 2'd1;
    localparam logic [QTY_W-1:0] QTY_MAF  = 2'd2;
    localparam logic [QTY_W-1:0] QTY_RPM  = 2'd3;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [VALUE_W-1:0] high;
        logic [VALUE_W-1:0] low;
    } stat_entry_t;

    function automatic logic [VALUE_W-1:0] range_top(input logic [QTY_W-1:0] qty);
        logic [VALUE_W-1:0] top;
        begin
            case (qty)
                QTY_TRIM: top = 14'd255;
                QTY_MAP:  top = 14'd4095;
                QTY_MAF:  top = 14'd8191;
                default:  top = 14'd16383;
            endcase
            return top;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/trim_cell_statistics.sv =====
// Top level of the trim cell statistics block: filter chain, per-cell store and
// a shared min/max/sum unit run by a small sequencer. Depends on tcs_pkg.
// A rejected or stored record gives a single result; a readout gives one result per
// cycle while the output is taken. The shared update unit handles one quantity a
// cycle, so a stored record keeps the block busy through all four quantities.
// Reset loads the control and configuration registers with their defaults and then
// sweeps the store, one entry a cycle, during which no request is accepted.
`default_nettype none

module trim_cell_statistics #(
    parameter int MAX_CELLS  = 256,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // timestamp, cell_req, coolant_temp, closed_loop, learn_enabled, wide_open,
    // left_trim, right_trim, map_tenths, maf_tenths, engine_rpm, zero padding
    input  wire logic [tcs_pkg::IN_DATA_W-1:0]    s_tdata,
    // op
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status, hit_count, reliable, minimum, maximum, total, zero padding
    output logic [tcs_pkg::OUT_DATA_W-1:0]        m_tdata,
    // quantity
    output logic [tcs_pkg::QTY_W-1:0]             m_tuser,
    output logic                                  m_tlast,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CELL_AW    = $clog2(MAX_CELLS);
    localparam int STAT_AW    = CELL_AW + 2;
    localparam int STAT_DEPTH = MAX_CELLS * 4;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_CHECK   = 6'b000100,
        ST_UPDATE  = 6'b001000,
        ST_SEND    = 6'b010000,
        ST_READOUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0]         min_timestamp_reg;
    logic signed [8:0]   min_coolant_reg;
    logic [13:0]         min_rpm_reg;
    logic [7:0]          cells_in_use_reg;
    logic [13:0]         reliable_hits_reg;

    logic                op_reg;
    logic [19:0]         timestamp_reg;
    logic [7:0]          cell_reg;
    logic signed [8:0]   coolant_reg;
    logic                closed_loop_reg;
    logic                learn_reg;
    logic                wide_open_reg;
    logic [7:0]          left_reg;
    logic [7:0]          right_reg;
    logic [11:0]         map_reg;
    logic [12:0]         maf_reg;
    logic [13:0]         rpm_reg;

    logic [1:0]          q_reg, q_next;
    logic [STAT_AW-1:0]  clr_reg;
    logic [tcs_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [COUNT_BITS-1:0] hit_mem [MAX_CELLS];
    tcs_pkg::stat_entry_t  stat_mem [STAT_DEPTH];
    logic [COUNT_BITS-1:0] hits_rd_reg;
    tcs_pkg::stat_entry_t  stat_rd_reg;

    logic                  hit_we;
    logic [CELL_AW-1:0]    hit_waddr;
    logic [COUNT_BITS-1:0] hit_wdata;
    logic                  stat_we;
    logic [STAT_AW-1:0]    stat_waddr;
    tcs_pkg::stat_entry_t  stat_wdata;

    logic                  out_valid_reg;
    logic [tcs_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [tcs_pkg::QTY_W-1:0] out_qty_reg;
    logic                  out_last_reg;
    logic                  out_load;
    logic                  out_free;

    logic [CELL_AW-1:0]    cell_idx;
    logic                  cell_ok;
    logic [tcs_pkg::STATUS_W-1:0] filter_status;
    logic                  hits_full;
    logic [8:0]            trim_sum;
    logic [13:0]           unit_value;
    logic [13:0]           unit_add;
    tcs_pkg::stat_entry_t  unit_result;
    logic [31:0]           hits_wide;
    logic                  reliable;

    assign cell_idx  = CELL_AW'(cell_reg);
    assign cell_ok   = (cell_reg < cells_in_use_reg) && (32'(cell_reg) < 32'(MAX_CELLS));
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign hits_full = (hits_rd_reg == {COUNT_BITS{1'b1}});
    assign hits_wide = 32'(hits_rd_reg);
    assign reliable  = (hits_wide > 32'(reliable_hits_reg));
    assign trim_sum  = 9'(left_reg) + 9'(right_reg);

    always_comb
    begin
        if (timestamp_reg < min_timestamp_reg)
            filter_status = tcs_pkg::STATUS_TIME;
        else if ((min_rpm_reg != 14'd0) && (rpm_reg < min_rpm_reg))
            filter_status = tcs_pkg::STATUS_RPM;
        else if (!cell_ok)
            filter_status = tcs_pkg::STATUS_CELL;
        else if (coolant_reg < min_coolant_reg)
            filter_status = tcs_pkg::STATUS_TEMP;
        else if (!closed_loop_reg || !learn_reg || wide_open_reg)
            filter_status = tcs_pkg::STATUS_MODE;
        else
            filter_status = tcs_pkg::STATUS_OK;
    end

    // Shared update unit: one quantity per cycle.
    always_comb
    begin
        case (q_reg)
            tcs_pkg::QTY_TRIM:
            begin
                unit_value = 14'(trim_sum[8:1]);
                unit_add   = 14'(trim_sum);
            end
            tcs_pkg::QTY_MAP:
            begin
                unit_value = 14'(map_reg);
                unit_add   = 14'(map_reg);
            end
            tcs_pkg::QTY_MAF:
            begin
                unit_value = 14'(maf_reg);
                unit_add   = 14'(maf_reg);
            end
            default:
            begin
                unit_value = rpm_reg;
                unit_add   = rpm_reg;
            end
        endcase
        unit_result.low   = (unit_value < stat_rd_reg.low) ? unit_value : stat_rd_reg.low;
        unit_result.high  = (unit_value > stat_rd_reg.high) ? unit_value : stat_rd_reg.high;
        unit_result.total = stat_rd_reg.total + tcs_pkg::TOTAL_W'(unit_add);
    end

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        status_next = status_reg;
        out_load    = 1'b0;
        hit_we      = 1'b0;
        hit_waddr   = cell_idx;
        hit_wdata   = hits_rd_reg + COUNT_BITS'(1);
        stat_we     = 1'b0;
        stat_waddr  = {cell_idx, q_reg};
        stat_wdata  = unit_result;
        unique case (state_reg)
            ST_CLEAR:
            begin
                hit_we           = 1'b1;
                hit_waddr        = clr_reg[STAT_AW-1:2];
                hit_wdata        = '0;
                stat_we          = 1'b1;
                stat_waddr       = clr_reg;
                stat_wdata.low   = tcs_pkg::range_top(clr_reg[1:0]);
                stat_wdata.high  = '0;
                stat_wdata.total = '0;
                if (32'(clr_reg) == 32'(STAT_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                q_next = 2'd0;
                if (s_tvalid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg)
                begin
                    if (cell_ok)
                        state_next = ST_READOUT;
                    else
                    begin
                        status_next = tcs_pkg::STATUS_CELL;
                        state_next  = ST_SEND;
                    end
                end
                else if (filter_status != tcs_pkg::STATUS_OK)
                begin
                    status_next = filter_status;
                    state_next  = ST_SEND;
                end
                else
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if ((q_reg == tcs_pkg::QTY_TRIM) && hits_full)
                begin
                    status_next = tcs_pkg::STATUS_FULL;
                    state_next  = ST_SEND;
                end
                else
                begin
                    stat_we = 1'b1;
                    hit_we  = (q_reg == tcs_pkg::QTY_TRIM);
                    q_next  = q_reg + 2'd1;
                    if (q_reg == tcs_pkg::QTY_RPM)
                    begin
                        status_next = tcs_pkg::STATUS_OK;
                        state_next  = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READOUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    q_next   = q_reg + 2'd1;
                    if (q_reg == tcs_pkg::QTY_RPM)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            q_reg             <= 2'd0;
            status_reg        <= tcs_pkg::STATUS_OK;
            out_valid_reg     <= 1'b0;
            min_timestamp_reg <= 20'd0;
            min_coolant_reg   <= -9'sd40;
            min_rpm_reg       <= 14'd0;
            cells_in_use_reg  <= 8'd255;
            reliable_hits_reg <= 14'd1;
        end
        else
        begin
            state_reg  <= state_next;
            q_reg      <= q_next;
            status_reg <= status_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + STAT_AW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    tcs_pkg::REG_MIN_TIMESTAMP: min_timestamp_reg <= cfg_data;
                    tcs_pkg::REG_MIN_COOLANT:   min_coolant_reg   <= signed'(cfg_data[8:0]);
                    tcs_pkg::REG_MIN_RPM:       min_rpm_reg       <= cfg_data[13:0];
                    tcs_pkg::REG_CELLS_IN_USE:  cells_in_use_reg  <= cfg_data[7:0];
                    tcs_pkg::REG_RELIABLE_HITS: reliable_hits_reg <= cfg_data[13:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg          <= s_tuser;
            timestamp_reg   <= s_tdata[19:0];
            cell_reg        <= s_tdata[27:20];
            coolant_reg     <= signed'(s_tdata[36:28]);
            closed_loop_reg <= s_tdata[37];
            learn_reg       <= s_tdata[38];
            wide_open_reg   <= s_tdata[39];
            left_reg        <= s_tdata[47:40];
            right_reg       <= s_tdata[55:48];
            map_reg         <= s_tdata[67:56];
            maf_reg         <= s_tdata[80:68];
            rpm_reg         <= s_tdata[94:81];
        end
        if (out_load)
        begin
            if (state_reg == ST_READOUT)
            begin
                out_data_reg <= {2'b00, stat_rd_reg.total, stat_rd_reg.high, stat_rd_reg.low,
                                 reliable, hits_wide[tcs_pkg::HITS_W-1:0],
                                 tcs_pkg::STATUS_OK};
                out_qty_reg  <= q_reg;
                out_last_reg <= (q_reg == tcs_pkg::QTY_RPM);
            end
            else
            begin
                out_data_reg <= {(tcs_pkg::OUT_DATA_W - tcs_pkg::STATUS_W)'(0), status_reg};
                out_qty_reg  <= tcs_pkg::QTY_TRIM;
                out_last_reg <= 1'b1;
            end
        end
    end

    // Store: one write and one registered read per cycle on each memory.
    always_ff @(posedge clk)
    begin
        if (hit_we)
            hit_mem[hit_waddr] <= hit_wdata;
        if (stat_we)
            stat_mem[stat_waddr] <= stat_wdata;
        hits_rd_reg <= hit_mem[cell_idx];
        stat_rd_reg <= stat_mem[{cell_idx, q_next}];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_qty_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
